FILE: rtl/core/pwbt_pkg.sv
// ----------------------------------------------------------------------------
// pwbt_pkg
// Shared types and constants of the page write buffer table: command and
// status codes, list codes and the scan result bundle.
// ----------------------------------------------------------------------------
package pwbt_pkg;

  // default slot count
  localparam int unsigned DefEntries = 16;

  // largest batch a take command may move
  localparam logic [4:0] MaxBatch = 5'd16;

  typedef enum logic [2:0] {
    CMD_PUT     = 3'd0,
    CMD_LOOKUP  = 3'd1,
    CMD_TAKE    = 3'd2,
    CMD_RELEASE = 3'd3,
    CMD_REMOVE  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_NO_FREE   = 2'd2,
    STS_TOO_FEW   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    LIST_FREE    = 2'd0,
    LIST_BUF     = 2'd1,
    LIST_WRITING = 2'd2
  } list_e;

  // outcome of an address scan
  typedef struct packed {
    logic done;
    logic hit;
  } scan_res_t;

endpackage

FILE: rtl/core/pwbt_ram.sv
// ----------------------------------------------------------------------------
// pwbt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pwbt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/pwbt_scan.sv
// ----------------------------------------------------------------------------
// pwbt_scan
// Address match unit: walks the slots in index order, one RAM read per
// cycle, and compares each mapped slot's address with the key.
// ----------------------------------------------------------------------------
module pwbt_scan
  import pwbt_pkg::*;
#(
  parameter int unsigned Entries = DefEntries,
  localparam int unsigned IdxW = $clog2(Entries)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [31:0]       key_i,
  input  logic [Entries-1:0] mapped_i,
  input  logic [31:0]       rdata_i,
  output logic [IdxW-1:0]   rd_idx_o,
  output logic [IdxW-1:0]   slot_o,
  output scan_res_t         res_o
);

  logic            busy_q;
  logic [IdxW-1:0] scan_q;
  logic            cmp_v_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic            hit;
  logic            at_end;

  // compare the slot read in the previous cycle
  always_comb begin
    hit    = cmp_v_q && mapped_i[cmp_idx_q] && (rdata_i == key_i);
    at_end = cmp_v_q && (cmp_idx_q == IdxW'(Entries - 1));
    res_o.done = busy_q && (hit || at_end);
    res_o.hit  = hit;
  end

  assign rd_idx_o = scan_q;
  assign slot_o   = cmp_idx_q;

  // walk counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      scan_q    <= '0;
      cmp_v_q   <= 1'b0;
      cmp_idx_q <= '0;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      scan_q  <= '0;
      cmp_v_q <= 1'b0;
    end else if (busy_q) begin
      if (res_o.done) begin
        busy_q  <= 1'b0;
        cmp_v_q <= 1'b0;
      end else begin
        cmp_v_q   <= 1'b1;
        cmp_idx_q <= scan_q;
        scan_q    <= scan_q + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/page_write_buffer_table.sv
// ----------------------------------------------------------------------------
// page_write_buffer_table
// Tag and order engine of a flash write buffer: slots on free, buffered and
// writing lists, linked in flops, with page addresses in a RAM.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o  | command, page_address, batch_count
//  out     | output    | out_valid_o / out_stall_i| status, result_address, slot_index,
//          |           |                          | slot_valid, buffered_total, last_of_run
//
//  put, lookup and remove scan the address RAM one slot per cycle through a
//  single comparator. take moves one page at a time and waits while the
//  output register is held; release splices the writing list onto the free list.
//  in_stall_o is high from an accepted transfer until its last result is
//  loaded into the output register; out_stall_i holds that register.
//  reset puts every slot on the free list in index order at once.
// ----------------------------------------------------------------------------
module page_write_buffer_table
  import pwbt_pkg::*;
#(
  parameter int unsigned ENTRIES = DefEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [31:0] page_address_i,
  input  logic [4:0]  batch_count_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] result_address_o,
  output logic [3:0]  slot_index_o,
  output logic        slot_valid_o,
  output logic [4:0]  buffered_total_o,
  output logic        last_of_run_o
);

  localparam int unsigned IdxW = $clog2(ENTRIES);
  localparam int unsigned LnkW = $clog2(ENTRIES + 1);
  localparam logic [LnkW-1:0] NoneLink = LnkW'(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_UNLINK, S_APPEND, S_TAKE_UNL, S_TAKE_APP, S_RELEASE, S_EMIT
  } state_e;

  state_e          state_q, state_d;
  cmd_e            cmd_q, cmd_d;
  logic [31:0]     addr_q, addr_d;
  logic [4:0]      rem_q, rem_d;
  logic [LnkW-1:0] tot_q, tot_d;
  logic [IdxW-1:0] cur_q, cur_d;
  status_e         sts_q, sts_d;
  logic            vld_q, vld_d;
  logic [LnkW-1:0] count_q, count_d;

  list_e           list_q [ENTRIES];
  list_e           list_d [ENTRIES];
  logic [LnkW-1:0] next_q [ENTRIES];
  logic [LnkW-1:0] next_d [ENTRIES];
  logic [LnkW-1:0] prev_q [ENTRIES];
  logic [LnkW-1:0] prev_d [ENTRIES];
  logic [LnkW-1:0] head_q [3];
  logic [LnkW-1:0] head_d [3];
  logic [LnkW-1:0] tail_q [3];
  logic [LnkW-1:0] tail_d [3];

  logic            out_valid_q, out_valid_d;
  status_e         out_sts_q, out_sts_d;
  logic [31:0]     out_addr_q, out_addr_d;
  logic [3:0]      out_slot_q, out_slot_d;
  logic            out_vld_q, out_vld_d;
  logic [4:0]      out_tot_q, out_tot_d;
  logic            out_last_q, out_last_d;

  logic            accept;
  logic            out_free;
  logic            scan_start;
  scan_res_t       scan_res;
  logic [IdxW-1:0] scan_rd_idx;
  logic [IdxW-1:0] scan_slot;
  logic [ENTRIES-1:0] mapped;
  logic [IdxW-1:0] raddr;
  logic [31:0]     rdata;
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;

  // list link scratch
  logic [IdxW-1:0] u_slot;
  list_e           u_list;
  logic [LnkW-1:0] u_prev, u_next;
  list_e           a_list;
  logic [LnkW-1:0] a_tail;
  logic [LnkW-1:0] r_head, r_tail, r_ftail;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      mapped[i] = (list_q[i] != LIST_FREE);
    end
  end

  // address RAM
  pwbt_ram #(
    .Width (32),
    .Depth (ENTRIES)
  ) u_addr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (addr_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // address match unit
  pwbt_scan #(
    .Entries (ENTRIES)
  ) u_scan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (scan_start),
    .key_i    (addr_q),
    .mapped_i (mapped),
    .rdata_i  (rdata),
    .rd_idx_o (scan_rd_idx),
    .slot_o   (scan_slot),
    .res_o    (scan_res)
  );

  // read address select
  always_comb begin
    unique case (state_q)
      S_SCAN:     raddr = scan_rd_idx;
      S_TAKE_UNL: raddr = head_q[LIST_BUF][IdxW-1:0];
      default:    raddr = cur_q;
    endcase
  end

  // sequencer and list updates
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    addr_d    = addr_q;
    rem_d     = rem_q;
    tot_d     = tot_q;
    cur_d     = cur_q;
    sts_d     = sts_q;
    vld_d     = vld_q;
    count_d   = count_q;
    list_d    = list_q;
    next_d    = next_q;
    prev_d    = prev_q;
    head_d    = head_q;
    tail_d    = tail_q;
    scan_start = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = head_q[LIST_FREE][IdxW-1:0];

    out_valid_d = out_valid_q && out_stall_i;
    out_sts_d   = out_sts_q;
    out_addr_d  = out_addr_q;
    out_slot_d  = out_slot_q;
    out_vld_d   = out_vld_q;
    out_tot_d   = out_tot_q;
    out_last_d  = out_last_q;

    u_slot = (state_q == S_TAKE_UNL) ? head_q[LIST_BUF][IdxW-1:0] : cur_q;
    u_list = list_q[u_slot];
    u_prev = prev_q[u_slot];
    u_next = next_q[u_slot];
    a_list = (state_q == S_TAKE_APP) ? LIST_WRITING :
             ((cmd_q == CMD_PUT) ? LIST_BUF : LIST_FREE);
    a_tail = tail_q[a_list];
    r_head = head_q[LIST_WRITING];
    r_tail = tail_q[LIST_WRITING];
    r_ftail = tail_q[LIST_FREE];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d  = cmd_e'(command_i);
          addr_d = page_address_i;
          rem_d  = batch_count_i;
          sts_d  = STS_OK;
          vld_d  = 1'b0;
          unique case (cmd_e'(command_i)) inside
            CMD_PUT, CMD_LOOKUP, CMD_REMOVE: begin
              scan_start = 1'b1;
              state_d    = S_SCAN;
            end
            CMD_TAKE: begin
              if (batch_count_i == 5'd0) begin
                state_d = S_EMIT;
              end else if ((batch_count_i > MaxBatch) ||
                           (8'(batch_count_i) > 8'(count_q))) begin
                sts_d   = STS_TOO_FEW;
                state_d = S_EMIT;
              end else begin
                tot_d   = count_q - LnkW'(batch_count_i);
                state_d = S_TAKE_UNL;
              end
            end
            CMD_RELEASE: state_d = S_RELEASE;
            default:     state_d = S_EMIT;
          endcase
        end
      end

      S_SCAN: begin
        if (scan_res.done) begin
          if (scan_res.hit) begin
            cur_d = scan_slot;
            if (cmd_q == CMD_LOOKUP) begin
              vld_d   = 1'b1;
              state_d = S_EMIT;
            end else begin
              state_d = S_UNLINK;
            end
          end else if (cmd_q == CMD_PUT) begin
            if (head_q[LIST_FREE] == NoneLink) begin
              sts_d   = STS_NO_FREE;
              state_d = S_EMIT;
            end else begin
              cur_d   = head_q[LIST_FREE][IdxW-1:0];
              ram_we  = 1'b1;
              state_d = S_UNLINK;
            end
          end else begin
            sts_d   = STS_NOT_FOUND;
            state_d = S_EMIT;
          end
        end
      end

      S_UNLINK, S_TAKE_UNL: begin
        if (u_prev == NoneLink) head_d[u_list] = u_next;
        else next_d[u_prev[IdxW-1:0]] = u_next;
        if (u_next == NoneLink) tail_d[u_list] = u_prev;
        else prev_d[u_next[IdxW-1:0]] = u_prev;
        next_d[u_slot] = NoneLink;
        prev_d[u_slot] = NoneLink;
        if ((u_list == LIST_BUF) && (count_q != '0)) begin
          count_d = count_q - 1'b1;
        end
        cur_d   = u_slot;
        state_d = (state_q == S_TAKE_UNL) ? S_TAKE_APP : S_APPEND;
      end

      S_APPEND, S_TAKE_APP: begin
        if ((state_q == S_APPEND) || out_free) begin
          prev_d[cur_q] = a_tail;
          next_d[cur_q] = NoneLink;
          if (a_tail == NoneLink) head_d[a_list] = LnkW'(cur_q);
          else next_d[a_tail[IdxW-1:0]] = LnkW'(cur_q);
          tail_d[a_list] = LnkW'(cur_q);
          list_d[cur_q]  = a_list;
          if (state_q == S_APPEND) begin
            if (cmd_q == CMD_PUT) count_d = count_q + 1'b1;
            vld_d   = 1'b1;
            state_d = S_EMIT;
          end else begin
            // one transfer per moved page
            out_valid_d = 1'b1;
            out_sts_d   = STS_OK;
            out_addr_d  = rdata;
            out_slot_d  = 4'(cur_q);
            out_vld_d   = 1'b1;
            out_tot_d   = 5'(tot_q);
            out_last_d  = (rem_q == 5'd1);
            rem_d       = rem_q - 5'd1;
            state_d     = (rem_q == 5'd1) ? S_IDLE : S_TAKE_UNL;
          end
        end
      end

      S_RELEASE: begin
        // splice the whole writing list onto the free tail
        if (r_head != NoneLink) begin
          if (r_ftail == NoneLink) head_d[LIST_FREE] = r_head;
          else next_d[r_ftail[IdxW-1:0]] = r_head;
          prev_d[r_head[IdxW-1:0]] = r_ftail;
          tail_d[LIST_FREE]    = r_tail;
          head_d[LIST_WRITING] = NoneLink;
          tail_d[LIST_WRITING] = NoneLink;
          for (int i = 0; i < ENTRIES; i++) begin
            if (list_q[i] == LIST_WRITING) list_d[i] = LIST_FREE;
          end
        end
        state_d = S_EMIT;
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sts_d   = sts_q;
          out_addr_d  = vld_q ? addr_q : 32'd0;
          out_slot_d  = vld_q ? 4'(cur_q) : 4'd0;
          out_vld_d   = vld_q;
          out_tot_d   = 5'(count_q);
          out_last_d  = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // state, lists and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        list_q[i] <= LIST_FREE;
        next_q[i] <= LnkW'(i + 1);
        prev_q[i] <= (i == 0) ? NoneLink : LnkW'(i - 1);
      end
      head_q[LIST_FREE]    <= '0;
      tail_q[LIST_FREE]    <= LnkW'(ENTRIES - 1);
      head_q[LIST_BUF]     <= NoneLink;
      tail_q[LIST_BUF]     <= NoneLink;
      head_q[LIST_WRITING] <= NoneLink;
      tail_q[LIST_WRITING] <= NoneLink;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      list_q      <= list_d;
      next_q      <= next_d;
      prev_q      <= prev_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    addr_q     <= addr_d;
    rem_q      <= rem_d;
    tot_q      <= tot_d;
    cur_q      <= cur_d;
    sts_q      <= sts_d;
    vld_q      <= vld_d;
    out_sts_q  <= out_sts_d;
    out_addr_q <= out_addr_d;
    out_slot_q <= out_slot_d;
    out_vld_q  <= out_vld_d;
    out_tot_q  <= out_tot_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_sts_q;
  assign result_address_o = out_addr_q;
  assign slot_index_o     = out_slot_q;
  assign slot_valid_o     = out_vld_q;
  assign buffered_total_o = out_tot_q;
  assign last_of_run_o    = out_last_q;

endmodule
